// ===== src/gtfb_pkg.sv =====
// ----------------------------------------------------------------------------
// gtfb_pkg: shared types and constants of the GELU forward/backward pipeline
// Fixed-point formats, datapath widths, stage payload structs and the tanh
// sample table that is built at elaboration.
// ----------------------------------------------------------------------------
package gtfb_pkg;

  // Field formats
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // Internal fixed-point formats: constants and tanh in Q30, |x| in Q24
  localparam int QC = 30;
  localparam int QX = 24;
  localparam longint unsigned QONE = 64'd1 << QC;

  // tanh table: samples over [0, 2**TANH_RANGE_LOG2], both ends included
  localparam int TANH_DEPTH      = 256;
  localparam int TANH_RANGE_LOG2 = 3;
  localparam int TANH_IDX_BITS   = $clog2(TANH_DEPTH);
  localparam int TANH_ADDR_BITS  = $clog2(TANH_DEPTH + 1);
  localparam int TANH_W          = QC;
  localparam int FR_BITS         = QX + TANH_RANGE_LOG2 - TANH_IDX_BITS;
  localparam int EXP_TERMS       = 20;

  // Datapath widths (bounds follow from a 16-bit Q4.12 input)
  localparam int A_W     = DATA_WIDTH;       // |x| in Q12
  localparam int X2_W    = 2 * A_W - 1;      // x^2, at most 2**30
  localparam int X3_W    = 34;               // x^3 in Q24, at most 2**33
  localparam int U_W     = 30;               // x + k1*x^3 in Q24
  localparam int E_W     = 34;               // 1 + 3*k1*x^2 in Q30
  localparam int INNER_W = 29;               // tanh argument in Q24
  localparam int D_W     = 33;               // k0*(1 + 3*k1*x^2) in Q30
  localparam int T_W     = QC + 1;           // tanh magnitude, up to 1.0
  localparam int SECH_W  = QC + 1;           // sech^2, up to 1.0
  localparam int FSUM_W  = QC + 2;           // 1 + tanh, up to 2.0
  localparam int P_W     = 28;               // |x| * sech^2 in Q24
  localparam int Q_W     = 36;               // derivative side term in Q30
  localparam int GS_W    = 38;               // unclamped gradient factor
  localparam int G_W     = QC + 3;           // clamped to [-2, 2] in Q30
  localparam int PROD_W  = DATA_WIDTH + G_W; // final product before rounding
  localparam int RND_W   = DATA_WIDTH + 2;   // rounded magnitude

  // Constants in Q30
  localparam logic [29:0] K0_Q30   = 30'd856722024;  // sqrt(2/pi)
  localparam logic [25:0] K1_Q30   = 26'd48012366;   // 0.044715
  localparam logic [27:0] K1X3_Q30 = 28'd144037097;  // 3 * 0.044715

  // Register map: word index on paddr[2]
  localparam logic [0:0] REG_MODE_SELECT = 1'b0;

  typedef logic [TANH_DEPTH:0][TANH_W-1:0] tanh_rom_t;

  // Fields that ride along every stage
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] xs;
    logic signed [DATA_WIDTH-1:0] us;
    logic                         last;
    logic                         neg;
    logic [A_W-1:0]               a;
  } item_t;

  // Polynomial section to tanh section
  typedef struct packed {
    item_t              item;
    logic [INNER_W-1:0] inner;
    logic [D_W-1:0]     d;
  } poly_t;

  // tanh section to output section
  typedef struct packed {
    item_t             item;
    logic [D_W-1:0]    d;
    logic [SECH_W-1:0] sech2;
    logic [FSUM_W-1:0] fsum;
  } tnh_t;

  // Unsigned quotient by restoring shift and subtract, elaboration only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned dv);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= dv) begin
        rem    = rem - dv;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f) in Q30 for f in [0, 1] in Q30, alternating power series
  function automatic longint unsigned exp_neg_unit(input longint unsigned f);
    longint          sum;
    longint unsigned term;
    sum  = longint'(QONE);
    term = QONE;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = udiv64((term * f) >> QC, 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      return 64'd0;
    end
    return 64'(sum);
  endfunction

  // Sample i holds tanh(8*i/DEPTH) in Q30
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t       rom;
    longint unsigned em1;
    longint unsigned y;
    longint unsigned m;
    longint unsigned e;
    rom = '0;
    em1 = exp_neg_unit(QONE);
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      y = (64'(i) << (QC + 1 + TANH_RANGE_LOG2)) >> TANH_IDX_BITS;
      m = y >> QC;
      e = exp_neg_unit(y & (QONE - 64'd1));
      for (longint unsigned j = 0; j < m; j++) begin
        e = (e * em1 + (QONE >> 1)) >> QC;
      end
      if (e > QONE) begin
        e = QONE;
      end
      rom[i] = TANH_W'(udiv64(((QONE - e) << QC) + ((QONE + e) >> 1), QONE + e));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ===== src/gtfb_poly.sv =====
// ----------------------------------------------------------------------------
// gtfb_poly: polynomial section
// Takes |x| apart from its sign and forms the tanh argument k0*(x + k1*x^3)
// and the derivative factor k0*(1 + 3*k1*x^2), at most two multiplies per stage.
// ----------------------------------------------------------------------------
module gtfb_poly (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [gtfb_pkg::DATA_WIDTH-1:0] x_value_i,
  input  logic signed [gtfb_pkg::DATA_WIDTH-1:0] upstream_grad_i,
  input  logic                                  vector_last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output gtfb_pkg::poly_t                       out_o
);
  import gtfb_pkg::*;

  localparam int NS = 5;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  item_t              it_q [NS];
  item_t              it_d;
  logic [X2_W-1:0]    x2_1_q, x2_1_d;
  logic [X2_W-1:0]    x2_2_q;
  logic [X3_W-1:0]    x3_q, x3_d;
  logic [U_W-1:0]     u_q, u_d;
  logic [E_W-1:0]     e_q, e_d;
  logic [INNER_W-1:0] inner_q, inner_d;
  logic [D_W-1:0]     d_q, d_d;

  // Stall chain: a stage takes new data when empty or when its successor moves
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
  end

  assign v_d = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_comb begin
    it_d.xs   = x_value_i;
    it_d.us   = upstream_grad_i;
    it_d.last = vector_last_i;
    it_d.neg  = x_value_i[DATA_WIDTH-1];
    it_d.a    = x_value_i[DATA_WIDTH-1] ? A_W'(-x_value_i) : A_W'(x_value_i);
  end

  always_comb begin
    x2_1_d  = X2_W'(32'(it_q[0].a) * 32'(it_q[0].a));
    x3_d    = X3_W'((47'(x2_1_q) * 47'(it_q[1].a)) >> FRAC_BITS);
    u_d     = U_W'(U_W'(it_q[2].a) << (QX - FRAC_BITS))
            + U_W'((60'(K1_Q30) * 60'(x3_q)) >> QC);
    e_d     = E_W'((59'(K1X3_Q30) * 59'(x2_2_q)) >> QX) + E_W'(QONE);
    inner_d = INNER_W'((60'(K0_Q30) * 60'(u_q)) >> QC);
    d_d     = D_W'((64'(K0_Q30) * 64'(e_q)) >> QC);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      it_q[0] <= it_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        it_q[k] <= it_q[k - 1];
      end
    end
    if (rdy[1]) begin
      x2_1_q <= x2_1_d;
    end
    if (rdy[2]) begin
      x2_2_q <= x2_1_q;
      x3_q   <= x3_d;
    end
    if (rdy[3]) begin
      u_q <= u_d;
      e_q <= e_d;
    end
    if (rdy[4]) begin
      inner_q <= inner_d;
      d_q     <= d_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_comb begin
    out_o.item  = it_q[NS-1];
    out_o.inner = inner_q;
    out_o.d     = d_q;
  end

endmodule

// ===== src/gtfb_tanh.sv =====
// ----------------------------------------------------------------------------
// gtfb_tanh: tanh section
// Reads two neighboring table samples, interpolates, and derives 1 + tanh
// and sech^2 = 1 - tanh^2.
// ----------------------------------------------------------------------------
module gtfb_tanh (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gtfb_pkg::poly_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gtfb_pkg::tnh_t  out_o
);
  import gtfb_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  item_t               it_q [NS];
  logic [D_W-1:0]      d_q [NS];

  logic [TANH_ADDR_BITS-1:0] lo_addr, hi_addr;
  logic [TANH_W-1:0]   lo_q, lo_d;
  logic [TANH_W-1:0]   hi_q, hi_d;
  logic [FR_BITS-1:0]  fr_q, fr_d;
  logic                big_q, big_d;
  logic [T_W-1:0]      t_q, t_d;
  logic [SECH_W-1:0]   sech2_q, sech2_d;
  logic [FSUM_W-1:0]   fsum_q, fsum_d;
  logic [TANH_W-1:0]   diff;
  logic [T_W-1:0]      step;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
  end

  assign v_d = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  // Table read: arguments past the last interval saturate to 1.0
  always_comb begin
    lo_addr = TANH_ADDR_BITS'(in_i.inner[FR_BITS +: TANH_IDX_BITS]);
    hi_addr = lo_addr + TANH_ADDR_BITS'(1);
    lo_d    = TANH_ROM[lo_addr];
    hi_d    = TANH_ROM[hi_addr];
    fr_d    = in_i.inner[FR_BITS-1:0];
    big_d   = |in_i.inner[INNER_W-1:FR_BITS+TANH_IDX_BITS];
  end

  // Interpolate toward the upper sample, truncating the step
  always_comb begin
    diff = (hi_q >= lo_q) ? (hi_q - lo_q) : (lo_q - hi_q);
    step = T_W'((49'(diff) * 49'(fr_q)) >> FR_BITS);
    if (big_q) begin
      t_d = T_W'(QONE);
    end else if (hi_q >= lo_q) begin
      t_d = T_W'(lo_q) + step;
    end else begin
      t_d = T_W'(lo_q) - step;
    end
  end

  always_comb begin
    sech2_d = SECH_W'(QONE) - SECH_W'((62'(t_q) * 62'(t_q)) >> QC);
    fsum_d  = it_q[1].neg ? (FSUM_W'(QONE) - FSUM_W'(t_q))
                          : (FSUM_W'(QONE) + FSUM_W'(t_q));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      it_q[0] <= in_i.item;
      d_q[0]  <= in_i.d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      fr_q    <= fr_d;
      big_q   <= big_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        it_q[k] <= it_q[k - 1];
        d_q[k]  <= d_q[k - 1];
      end
    end
    if (rdy[1]) begin
      t_q <= t_d;
    end
    if (rdy[2]) begin
      sech2_q <= sech2_d;
      fsum_q  <= fsum_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_comb begin
    out_o.item  = it_q[NS-1];
    out_o.d     = d_q[NS-1];
    out_o.sech2 = sech2_q;
    out_o.fsum  = fsum_q;
  end

`ifndef NO_ASSERTIONS
  a_big_gives_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && rdy[1] && big_q) |=> (t_q == T_W'(QONE)))
    else $error("tanh above table range did not saturate to one");

  a_sech2_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && rdy[2]) |=> (sech2_q <= SECH_W'(QONE)))
    else $error("sech^2 exceeds one");

  a_fsum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && rdy[2]) |=> (fsum_q <= FSUM_W'(2 * QONE)))
    else $error("1 + tanh exceeds two");
`endif

endmodule

// ===== src/gtfb_grad.sv =====
// ----------------------------------------------------------------------------
// gtfb_grad: output section
// Forms the gradient factor, multiplies by x or by the upstream gradient,
// rounds half away from zero and saturates into the output register.
// ----------------------------------------------------------------------------
module gtfb_grad (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   mode_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  gtfb_pkg::tnh_t                         in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [gtfb_pkg::DATA_WIDTH-1:0] result_value_o,
  output logic                                   vector_last_o
);
  import gtfb_pkg::*;

  localparam int NS = 4;
  localparam logic signed [GS_W-1:0] G_HI = GS_W'(2 * QONE);
  localparam logic [RND_W-1:0] SAT_POS = RND_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [RND_W-1:0] SAT_NEG = SAT_POS + RND_W'(1);

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  // Stage G0
  item_t                  it0_q;
  logic [P_W-1:0]         p_q, p_d;
  logic [D_W-1:0]         d_q;
  logic [FSUM_W-1:0]      fsum0_q;
  // Stage G1
  item_t                  it1_q;
  logic signed [G_W-1:0]  g_q, g_d;
  logic [FSUM_W-1:0]      fsum1_q;
  // Stage G2
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                   sh31_q;
  logic                   last2_q;
  // Stage G3, output register
  logic signed [DATA_WIDTH-1:0] res_q, res_d;
  logic                   last3_q;

  logic [Q_W-1:0]         q;
  logic [FSUM_W-2:0]      half;
  logic signed [GS_W-1:0] gsum;
  logic [PROD_W-2:0]      mag;
  logic [PROD_W-2:0]      rsum;
  logic [RND_W-1:0]       rnd;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
  end

  assign v_d = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  // |x| * sech^2, with |x| in Q12 the Q30 product drops 18 bits
  assign p_d = P_W'((47'(in_i.item.a) * 47'(in_i.sech2)) >> (QC - (QX - FRAC_BITS)));

  // 0.5*(1 + tanh) +- 0.5*|x|*sech^2*d, clamped to [-2, 2]
  always_comb begin
    q    = Q_W'((61'(p_q) * 61'(d_q)) >> (QX + 1));
    half = fsum0_q[FSUM_W-1:1];
    if (it0_q.neg) begin
      gsum = $signed(GS_W'(half)) - $signed(GS_W'(q));
    end else begin
      gsum = $signed(GS_W'(half)) + $signed(GS_W'(q));
    end
    if (gsum > G_HI) begin
      g_d = G_W'(G_HI);
    end else if (gsum < -G_HI) begin
      g_d = G_W'(-G_HI);
    end else begin
      g_d = G_W'(gsum);
    end
  end

  // The user must keep mode static while items are in flight; the block does not enforce it
  always_comb begin
    if (mode_i) begin
      prod_d = PROD_W'(it1_q.us) * PROD_W'(g_q);
    end else begin
      prod_d = PROD_W'(it1_q.xs) * PROD_W'($signed({1'b0, fsum1_q}));
    end
  end

  // Round half away from zero, then saturate
  always_comb begin
    mag  = prod_q[PROD_W-1] ? (PROD_W-1)'(-prod_q) : (PROD_W-1)'(prod_q);
    rsum = mag + (sh31_q ? ((PROD_W-1)'(1) << QC) : ((PROD_W-1)'(1) << (QC - 1)));
    rnd  = sh31_q ? RND_W'(rsum >> (QC + 1)) : RND_W'(rsum >> QC);
    if (prod_q[PROD_W-1]) begin
      res_d = (rnd > SAT_NEG) ? DATA_WIDTH'(~SAT_NEG + RND_W'(1))
                              : DATA_WIDTH'(~rnd + RND_W'(1));
    end else begin
      res_d = (rnd > SAT_POS) ? DATA_WIDTH'(SAT_POS) : DATA_WIDTH'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      it0_q   <= in_i.item;
      p_q     <= p_d;
      d_q     <= in_i.d;
      fsum0_q <= in_i.fsum;
    end
    if (rdy[1]) begin
      it1_q   <= it0_q;
      g_q     <= g_d;
      fsum1_q <= fsum0_q;
    end
    if (rdy[2]) begin
      prod_q  <= prod_d;
      sh31_q  <= !mode_i;
      last2_q <= it1_q.last;
    end
    if (rdy[3]) begin
      res_q   <= res_d;
      last3_q <= last2_q;
    end
  end

  assign in_ready_o     = rdy[0];
  assign out_valid_o    = v_q[NS-1];
  assign result_value_o = res_q;
  assign vector_last_o  = last3_q;

endmodule

// ===== src/gelu_tanh_forward_backward.sv =====
// ----------------------------------------------------------------------------
// gelu_tanh_forward_backward: tanh-approximated GELU, value or gradient
// Pipeline: 12 register stages from the input transfer to the output register.
// Throughput: one transfer per cycle while the output side is ready; every stage stalls only when it is full
//   and its successor is held, so bubbles collapse during output back-pressure.
// Reset: rst_ni clears all valid bits and mode_select; data registers hold.
// ----------------------------------------------------------------------------
module gelu_tanh_forward_backward (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_value, [31:16] upstream_grad
  input  logic        s_axis_tlast,   // vector_last_in
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] result_value
  output logic        m_axis_tlast,   // vector_last_out
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gtfb_pkg::*;

  logic       mode_q, mode_d;
  logic       cfg_wr;
  logic [0:0] reg_idx;

  logic   poly_valid, poly_ready;
  poly_t  poly_data;
  logic   tnh_valid, tnh_ready;
  tnh_t   tnh_data;
  logic signed [DATA_WIDTH-1:0] result_value;

  // --------------------------------------------------------------------------
  // Configuration: one word register, written in the access phase.
  // Keep only bit 0 of mode_select; writes to other words are dropped.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    mode_d = mode_q;
    if (cfg_wr && (reg_idx == REG_MODE_SELECT)) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODE_SELECT) begin
      prdata = 32'(mode_q);
    end
  end

  // --------------------------------------------------------------------------
  // Polynomial section: |x|, x^2, x^3, tanh argument and derivative factor
  // --------------------------------------------------------------------------
  gtfb_poly u_poly (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .x_value_i       (s_axis_tdata[15:0]),
    .upstream_grad_i (s_axis_tdata[31:16]),
    .vector_last_i   (s_axis_tlast),
    .out_valid_o     (poly_valid),
    .out_ready_i     (poly_ready),
    .out_o           (poly_data)
  );

  // --------------------------------------------------------------------------
  // tanh section: table lookup, interpolation, 1 + tanh and sech^2
  // --------------------------------------------------------------------------
  gtfb_tanh u_tanh (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poly_valid),
    .in_ready_o  (poly_ready),
    .in_i        (poly_data),
    .out_valid_o (tnh_valid),
    .out_ready_i (tnh_ready),
    .out_o       (tnh_data)
  );

  // --------------------------------------------------------------------------
  // Output section: gradient factor, final product, round and saturate.
  // Its last stage is the output register; while a finished result waits there,
  // the input side keeps taking transfers only until the stages behind it are full.
  // --------------------------------------------------------------------------
  gtfb_grad u_grad (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .in_valid_i     (tnh_valid),
    .in_ready_o     (tnh_ready),
    .in_i           (tnh_data),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_value_o (result_value),
    .vector_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = result_value;

`ifndef NO_ASSERTIONS
  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output side is ready");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (reg_idx == REG_MODE_SELECT))
      |=> (mode_q == $past(pwdata[0])))
    else $error("mode_select write was not taken");

  a_reset_empties: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule
